FILE: sv/tcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, command codes and structured types for the renderer.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int COORD_BITS  = 12;

  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int CODE_W      = $clog2(GLYPH_COUNT);
  localparam int GADDR_W     = CODE_W + ROW_W;
  localparam int DIM_W       = 13;
  localparam int COLOUR_W    = 32;
  localparam int KIND_W      = 3;
  localparam int PADDR_W     = 4;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  localparam logic [DIM_W-1:0] CELL_W     = DIM_W'(8);
  localparam logic [DIM_W-1:0] CELL_H     = DIM_W'(16);
  localparam logic [DIM_W-1:0] COORD_SPAN = DIM_W'(1 << COORD_BITS);
  localparam logic [7:0]       FULL_MASK  = 8'hFF;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_PUT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOME    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FG     = 2'd2;
  localparam logic [1:0] REG_CLEAR  = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]    canvas_width;
    logic [DIM_W-1:0]    canvas_height;
    logic [COLOUR_W-1:0] foreground_colour;
    logic [COLOUR_W-1:0] clear_colour;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] emit_x;
    logic [COORD_BITS-1:0] emit_y;
  } cur_step_t;

endpackage

FILE: sv/tcg_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one console command per beat.
// ----------------------------------------------------------------------------
interface tcg_cmd_if import tcg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] char_code;
  logic [ROW_W-1:0]  glyph_row;
  logic [7:0]        glyph_bits;

  modport source (output valid, kind, char_code, glyph_row, glyph_bits, input ready);
  modport sink   (input valid, kind, char_code, glyph_row, glyph_bits, output ready);
endinterface

FILE: sv/tcg_row_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row write channel
// Valid/ready channel carrying one eight-pixel framebuffer row write per beat.
// ----------------------------------------------------------------------------
interface tcg_row_if import tcg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] row_x;
  logic [COORD_BITS-1:0] row_y;
  logic [7:0]            pixel_mask;
  logic [COLOUR_W-1:0]   pixel_value;
  logic                  last_row;

  modport source (output valid, row_x, row_y, pixel_mask, pixel_value, last_row,
                  input ready);
  modport sink   (input valid, row_x, row_y, pixel_mask, pixel_value, last_row,
                  output ready);
endinterface

FILE: sv/tcg_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Renderer configuration registers
// APB-style register file holding canvas size and the two colours.
// ----------------------------------------------------------------------------
module tcg_apb_regs import tcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width      <= DIM_W'(640);
      cfg_q.canvas_height     <= DIM_W'(480);
      cfg_q.foreground_colour <= 32'hFFFF_FFFF;
      cfg_q.clear_colour      <= 32'h0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  cfg_q.canvas_width      <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_q.canvas_height     <= pwdata[DIM_W-1:0];
        REG_FG:     cfg_q.foreground_colour <= pwdata;
        REG_CLEAR:  cfg_q.clear_colour      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, cfg_q.canvas_width};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, cfg_q.canvas_height};
      REG_FG:     prdata = cfg_q.foreground_colour;
      REG_CLEAR:  prdata = cfg_q.clear_colour;
      default:    prdata = 32'h0;
    endcase
  end

endmodule

FILE: sv/tcg_glyph_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph store
// Single-port-write, registered-read memory of glyph rows, one byte per row.
// ----------------------------------------------------------------------------
module tcg_glyph_mem import tcg_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [GADDR_W-1:0] wr_addr_i,
  input  logic [7:0]         wr_data_i,
  input  logic               rd_en_i,
  input  logic [GADDR_W-1:0] rd_addr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem_q [GLYPH_COUNT*GLYPH_ROWS];
  logic [7:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  // A read and a write to the same entry in one cycle return the old byte.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: sv/tcg_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor unit
// Holds the text cursor and works out its next position and the cell origin.
// ----------------------------------------------------------------------------
module tcg_cursor import tcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_en_i,
  input  logic [KIND_W-1:0] kind_i,
  input  cfg_t              cfg_i,
  output cur_step_t         step_o
);

  logic [COORD_BITS-1:0] x_q, x_d;
  logic [COORD_BITS-1:0] y_q, y_d;
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [DIM_W-1:0]      x_adv, y_inc, y_pre, y_pull, xb;
  logic [COORD_BITS-1:0] yb;
  logic                  wrap;

  always_comb begin
    if (cfg_i.canvas_width < CELL_W) begin
      w_eff = CELL_W;
    end else if (cfg_i.canvas_width > COORD_SPAN) begin
      w_eff = COORD_SPAN;
    end else begin
      w_eff = cfg_i.canvas_width;
    end
    if (cfg_i.canvas_height < CELL_H) begin
      h_eff = CELL_H;
    end else if (cfg_i.canvas_height > COORD_SPAN) begin
      h_eff = COORD_SPAN;
    end else begin
      h_eff = cfg_i.canvas_height;
    end
  end

  assign x_adv = {1'b0, x_q} + CELL_W;
  assign wrap  = ({1'b0, x_adv} + {1'b0, CELL_W}) > {1'b0, w_eff};
  assign y_inc = {1'b0, y_q} + CELL_H;

  // Backspace from the start of a line steps to the end of the line above (of the top line when already on it).
  always_comb begin
    if ({1'b0, x_q} < CELL_W) begin
      xb = w_eff;
      yb = ({1'b0, y_q} >= CELL_H) ? y_q - COORD_BITS'(CELL_H) : '0;
    end else begin
      xb = {1'b0, x_q};
      yb = y_q;
    end
  end

  // The pull-back compare is shared by put-char and newline.
  assign y_pre  = (((kind_i == KIND_PUT) && wrap) || (kind_i == KIND_NEWLINE)) ?
                  y_inc : {1'b0, y_q};
  assign y_pull = (y_pre > (h_eff - CELL_H)) ? y_pre - CELL_H : y_pre;

  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    step_o.emit_x = x_q;
    step_o.emit_y = y_q;
    case (kind_i)
      KIND_PUT: begin
        x_d   = wrap ? '0 : x_adv[COORD_BITS-1:0];
        y_d   = y_pull[COORD_BITS-1:0];
      end
      KIND_BACK: begin
        x_d           = COORD_BITS'(xb - CELL_W);
        y_d           = yb;
        step_o.emit_x = x_d;
        step_o.emit_y = yb;
      end
      KIND_NEWLINE: begin
        x_d   = '0;
        y_d   = y_pull[COORD_BITS-1:0];
      end
      KIND_HOME: begin
        x_d = '0;
        y_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (upd_en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

FILE: sv/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Turns console commands into eight-pixel framebuffer row writes.
// ----------------------------------------------------------------------------
// Commands arrive as beats on cmd_i; row writes leave as beats on row_o. The
// APB port sets canvas size and colours and should be written only while idle.
// A put-char or backspace produces 16 row beats, one per cycle while row_o is
// ready. The command beat sets the sequencer running, and each row then
// passes through the glyph store read and the output register. A row counter
// steps the glyph store's registered read port once per row, and the next
// command is taken on the cycle the last row is issued. Newline, cursor home
// and glyph loads never enter the run state and produce no rows.
// When row_o stalls, the read pipeline and row counter hold and cmd_i.ready
// stays low until the last row of the current cell has been issued.
// Reset clears the cursor, the sequencer and the output valid and restores the
// register defaults; the glyph store is not cleared and must be loaded before
// characters are drawn.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer import tcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcg_cmd_if.sink            cmd_i,
  tcg_row_if.source          row_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  cfg_t      cfg;
  cur_step_t step;

  logic state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [CODE_W-1:0]     code_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [COLOUR_W-1:0]   colour_q;
  logic                  erase_q;

  logic                  s1_valid_q;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic [COLOUR_W-1:0]   s1_colour_q;
  logic                  s1_erase_q, s1_last_q;

  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [7:0]            out_mask_q;
  logic [COLOUR_W-1:0]   out_colour_q;
  logic                  out_last_q;

  logic       advance, issue, done_issue, in_ready, accept, draw_cmd, is_back;
  logic [7:0] rd_data;

  tcg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcg_cursor u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (accept),
    .kind_i   (cmd_i.kind),
    .cfg_i    (cfg),
    .step_o   (step)
  );

  tcg_glyph_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (cmd_i.kind == KIND_LOAD)),
    .wr_addr_i ({cmd_i.char_code, cmd_i.glyph_row}),
    .wr_data_i (cmd_i.glyph_bits),
    .rd_en_i   (issue),
    .rd_addr_i ({code_q, row_q}),
    .rd_data_o (rd_data)
  );

  assign advance    = !out_valid_q || row_o.ready;
  assign issue      = (state_q == ST_RUN) && advance;
  assign done_issue = issue && (row_q == ROW_LAST);
  assign in_ready   = (state_q == ST_IDLE) || done_issue;
  assign accept     = cmd_i.valid && in_ready;
  assign is_back    = (cmd_i.kind == KIND_BACK);
  assign draw_cmd   = (cmd_i.kind == KIND_PUT) || is_back;

  assign cmd_i.ready = in_ready;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    if (accept && draw_cmd) begin
      state_d = ST_RUN;
      row_d   = '0;
    end else if (done_issue) begin
      state_d = ST_IDLE;
    end else if (issue) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (advance) begin
        s1_valid_q  <= issue;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Cell parameters are latched per drawing command and carried with every row so
  // that rows still in flight are not disturbed by the next command.
  always_ff @(posedge clk_i) begin
    if (accept && draw_cmd) begin
      code_q   <= cmd_i.char_code;
      x_q      <= step.emit_x;
      y_q      <= step.emit_y;
      colour_q <= is_back ? cfg.clear_colour : cfg.foreground_colour;
      erase_q  <= is_back;
    end
    if (issue) begin
      s1_x_q      <= x_q;
      s1_y_q      <= y_q + {{(COORD_BITS-ROW_W){1'b0}}, row_q};
      s1_colour_q <= colour_q;
      s1_erase_q  <= erase_q;
      s1_last_q   <= (row_q == ROW_LAST);
    end
    if (advance && s1_valid_q) begin
      out_x_q      <= s1_x_q;
      out_y_q      <= s1_y_q;
      out_mask_q   <= s1_erase_q ? FULL_MASK : rd_data;
      out_colour_q <= s1_colour_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign row_o.valid       = out_valid_q;
  assign row_o.row_x       = out_x_q;
  assign row_o.row_y       = out_y_q;
  assign row_o.pixel_mask  = out_mask_q;
  assign row_o.pixel_value = out_colour_q;
  assign row_o.last_row    = out_last_q;

endmodule
